@@ hdl/gqlc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the glyph quad layout clipper.
package gqlc_pkg;

	// Coordinate and texture widths
	localparam int COORD_BITS   = 16;
	localparam int UV_FRAC_BITS = 16;
	localparam int UV_W         = UV_FRAC_BITS + 1;
	localparam int WIN_W        = COORD_BITS + 2;
	localparam int PROD_W       = COORD_BITS + UV_W;
	localparam int DIV_W        = PROD_W + 1;
	localparam int QS_W         = UV_W + 1;
	localparam int UVR_W        = UV_W + 2;
	localparam int SIZE_W       = 8;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	// Control characters
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_TAB     = 8'd9;

	// Sequencer end marks
	localparam logic [2:0] LAST_VERTEX = 3'd5;
	localparam logic [2:0] LAST_STEP   = 3'd7;
	localparam logic [1:0] LAST_JOB    = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GLYPH_HEIGHT = 3'd0,
		REG_SPACE_WIDTH  = 3'd1,
		REG_TAB_COUNT    = 3'd2,
		REG_CLIP_ENABLE  = 3'd3,
		REG_CLIP_LEFT    = 3'd4,
		REG_CLIP_TOP     = 3'd5,
		REG_CLIP_WIDTH   = 3'd6,
		REG_CLIP_HEIGHT  = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PEN,
		ST_WIN,
		ST_CLIP,
		ST_DELTA,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_UV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic            first_char;
		logic [7:0]      char_code;
		logic [7:0]      advance;
		logic [UV_W-1:0] tl_u;
		logic [UV_W-1:0] tl_v;
		logic [UV_W-1:0] bl_u;
		logic [UV_W-1:0] bl_v;
		logic [UV_W-1:0] tr_u;
		logic [UV_W-1:0] tr_v;
		logic [UV_W-1:0] br_u;
		logic [UV_W-1:0] br_v;
	} gqlc_req_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] vert_x;
		logic [COORD_BITS-1:0] vert_y;
		logic [UV_W-1:0]       vert_u;
		logic [UV_W-1:0]       vert_v;
		logic                  quad_done;
	} gqlc_vtx_t;

	// Corner of each emitted vertex: p2, p0, p1, p3, p2, p1
	function automatic logic [1:0] corner_of(input logic [2:0] vidx);
		logic [1:0] k;
		case (vidx)
			3'd0: k = 2'd2;
			3'd1: k = 2'd0;
			3'd2: k = 2'd1;
			3'd3: k = 2'd3;
			3'd4: k = 2'd2;
			3'd5: k = 2'd1;
			default: k = 2'd0;
		endcase
		return k;
	endfunction

	// Add two coordinates, saturating at the top of the range
	function automatic logic [COORD_BITS-1:0] sat_add(input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b);
		logic [COORD_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COORD_BITS] ? {COORD_BITS{1'b1}} : s[COORD_BITS-1:0];
	endfunction

endpackage

@@ hdl/gqlc_div.sv @@
`timescale 1ns / 1ps
// Restoring divider producing one quotient bit per cycle.
module gqlc_div #(
	parameter int DIVIDEND_W = 34,
	parameter int DIVISOR_W  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    trial_sub;
	logic                  fits;

	// Trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial     = {rem_q, quo_q[DIVIDEND_W-1]};
		trial_sub = trial - {1'b0, dsr_q};
		fits      = trial >= {1'b0, dsr_q};
	end

	// Step count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift dividend out and quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ hdl/glyph_quad_layout_clipper.sv @@
`timescale 1ns / 1ps
// Top level: pen tracking, clip window, texture shift sequencer and vertex output.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | gqlc_req_t, one character
//  vtx     | out       | vtx_valid / vtx_ready | gqlc_vtx_t, one vertex
//  cfg     | in        | cfg_we                | cfg_index, cfg_data
//
// One character at a time. Space, tab and newline only move the pen.
// Glyph without clipping: one vertex per cycle as the output drains.
// Clipped glyph: window and clip tests, then 4 texture shifts, each one whose offset,
// texture span and glyph size are nonzero going through the 34-step shared divider,
// then the texture update and 6 vertices. A culled glyph or a zero-size window emits none.
// Reset sets state, pen, counters and configuration; a stalled output holds its vertex.
module glyph_quad_layout_clipper (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  gqlc_pkg::gqlc_req_t                 req,
	output logic                                vtx_valid,
	input  logic                                vtx_ready,
	output gqlc_pkg::gqlc_vtx_t                 vtx,
	input  logic                                cfg_we,
	input  logic [gqlc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gqlc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import gqlc_pkg::*;

	state_t state_q, state_d;

	// Configuration registers
	logic [7:0]            gh_q;
	logic [7:0]            sw_q;
	logic [4:0]            tc_q;
	logic                  clip_en_q;
	logic [15:0]           clip_l_q;
	logic [15:0]           clip_t_q;
	logic [15:0]           clip_w_q;
	logic [15:0]           clip_h_q;

	// Pen and current item
	logic [COORD_BITS-1:0] pen_x_q, pen_y_q;
	gqlc_req_t             item_q;
	logic [COORD_BITS-1:0] x0_q, x1_q, y0_q, y1_q;
	logic [COORD_BITS-1:0] xl_q, xh_q, yt_q, yb_q;
	logic signed [WIN_W-1:0] win_l_q, win_t_q, win_r_q, win_b_q;
	logic [UV_W-1:0]       du_mag_q, dv_mag_q;
	logic                  du_neg_q, dv_neg_q;
	logic [COORD_BITS-1:0] d_q [4];
	logic [1:0]            job_q;
	logic [PROD_W-1:0]     prod_q;
	logic                  pneg_q;
	logic                  skip_q;
	logic [QS_W-1:0]       qs_q [4];
	logic                  qneg_q [4];
	logic [UV_W-1:0]       u_q [4];
	logic [UV_W-1:0]       v_q [4];
	logic [2:0]            step_q;
	logic [2:0]            vidx_q;
	gqlc_vtx_t             vtx_q;
	logic                  vtx_valid_q;

	// Combinational helpers
	logic                  div_start, div_done, vtx_load;
	logic [DIV_W-1:0]      div_quot;
	logic [COORD_BITS-1:0] base_x, base_y, x1_new, y1_new, tab_adv;
	logic signed [WIN_W-1:0] x0_s, x1_s, y0_s, y1_s, cl_s, ct_s;
	logic                  cull;
	logic [COORD_BITS-1:0] d_sel;
	logic [UV_W-1:0]       mag_sel;
	logic [SIZE_W-1:0]     size_sel;
	logic [1:0]            rd_k;
	logic [1:0]            uv_k;
	logic                  uv_isv;
	logic [1:0]            uv_job;
	logic [UV_W-1:0]       uv_base;
	logic signed [UVR_W-1:0] uv_sum;
	logic [UV_W-1:0]       uv_new;
	logic [1:0]            em_k;
	logic                  is_ctrl;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gh_q      <= 8'd16;
			sw_q      <= 8'd8;
			tc_q      <= 5'd4;
			clip_en_q <= 1'b0;
			clip_l_q  <= 16'd0;
			clip_t_q  <= 16'd0;
			clip_w_q  <= 16'hFFFF;
			clip_h_q  <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GLYPH_HEIGHT: gh_q      <= cfg_data[7:0];
				REG_SPACE_WIDTH:  sw_q      <= cfg_data[7:0];
				REG_TAB_COUNT:    tc_q      <= cfg_data[4:0];
				REG_CLIP_ENABLE:  clip_en_q <= cfg_data[0];
				REG_CLIP_LEFT:    clip_l_q  <= cfg_data[15:0];
				REG_CLIP_TOP:     clip_t_q  <= cfg_data[15:0];
				REG_CLIP_WIDTH:   clip_w_q  <= cfg_data[15:0];
				REG_CLIP_HEIGHT:  clip_h_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Pen arithmetic, window tests and shift operand selection
	always_comb begin
		base_x  = item_q.first_char ? '0 : pen_x_q;
		base_y  = item_q.first_char ? '0 : pen_y_q;
		x1_new  = sat_add(base_x, COORD_BITS'(item_q.advance));
		y1_new  = sat_add(base_y, COORD_BITS'(gh_q));
		tab_adv = COORD_BITS'(sw_q) * COORD_BITS'(tc_q);
		is_ctrl = (item_q.char_code == CH_NEWLINE) || (item_q.char_code == CH_SPACE) ||
			(item_q.char_code == CH_TAB);

		x0_s = {{(WIN_W-COORD_BITS){1'b0}}, x0_q};
		x1_s = {{(WIN_W-COORD_BITS){1'b0}}, x1_q};
		y0_s = {{(WIN_W-COORD_BITS){1'b0}}, y0_q};
		y1_s = {{(WIN_W-COORD_BITS){1'b0}}, y1_q};
		cl_s = {{(WIN_W-16){clip_l_q[15]}}, clip_l_q};
		ct_s = {{(WIN_W-16){clip_t_q[15]}}, clip_t_q};
		cull = (x1_s <= win_l_q) || (y1_s <= win_t_q) || (x0_s >= win_r_q) ||
			(y0_s >= win_b_q);

		d_sel    = d_q[job_q];
		mag_sel  = job_q[1] ? dv_mag_q : du_mag_q;
		size_sel = job_q[1] ? gh_q : item_q.advance;

		em_k = corner_of(vidx_q);
		uv_k = step_q[2:1];
		rd_k = (state_q == ST_EMIT) ? em_k : uv_k;
	end

	// Apply one texture shift with saturation
	always_comb begin
		uv_isv  = step_q[0];
		uv_job  = uv_isv ? {1'b1, uv_k[0]} : {1'b0, uv_k[1]};
		uv_base = uv_isv ? v_q[rd_k] : u_q[rd_k];
		if (qneg_q[uv_job])
			uv_sum = UVR_W'(uv_base) - UVR_W'(qs_q[uv_job]);
		else
			uv_sum = UVR_W'(uv_base) + UVR_W'(qs_q[uv_job]);
		if (uv_sum[UVR_W-1])
			uv_new = '0;
		else if (|uv_sum[UVR_W-2:UV_W])
			uv_new = '1;
		else
			uv_new = uv_sum[UV_W-1:0];
	end

	// Next state and handshake strobes
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		div_start = 1'b0;
		vtx_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid)
					state_d = ST_PEN;
			end
			ST_PEN: begin
				if (is_ctrl)
					state_d = ST_IDLE;
				else if (!clip_en_q)
					state_d = ST_EMIT;
				else if ((clip_w_q == '0) || (clip_h_q == '0))
					state_d = ST_IDLE;
				else
					state_d = ST_WIN;
			end
			ST_WIN: state_d = ST_CLIP;
			ST_CLIP: state_d = cull ? ST_IDLE : ST_DELTA;
			ST_DELTA: state_d = ST_MUL;
			ST_MUL: state_d = ST_DIV_GO;
			ST_DIV_GO: begin
				if (skip_q)
					state_d = (job_q == LAST_JOB) ? ST_UV : ST_MUL;
				else begin
					div_start = 1'b1;
					state_d   = ST_DIV_WAIT;
				end
			end
			ST_DIV_WAIT: begin
				if (div_done)
					state_d = (job_q == LAST_JOB) ? ST_UV : ST_MUL;
			end
			ST_UV: begin
				if (step_q == LAST_STEP)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				vtx_load = !vtx_valid_q || vtx_ready;
				if (vtx_load && (vidx_q == LAST_VERTEX))
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State, pen and sequence counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pen_x_q     <= '0;
			pen_y_q     <= '0;
			job_q       <= '0;
			step_q      <= '0;
			vidx_q      <= '0;
			vtx_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (vtx_load)
				vtx_valid_q <= 1'b1;
			else if (vtx_ready)
				vtx_valid_q <= 1'b0;
			case (state_q)
				ST_PEN: begin
					vidx_q  <= '0;
					pen_y_q <= base_y;
					if (item_q.char_code == CH_NEWLINE) begin
						pen_x_q <= '0;
						pen_y_q <= y1_new;
					end else if (item_q.char_code == CH_SPACE)
						pen_x_q <= sat_add(base_x, COORD_BITS'(sw_q));
					else if (item_q.char_code == CH_TAB)
						pen_x_q <= sat_add(base_x, tab_adv);
					else
						pen_x_q <= x1_new;
				end
				ST_DELTA: begin
					job_q  <= '0;
					step_q <= '0;
				end
				ST_DIV_GO: begin
					if (skip_q)
						job_q <= job_q + 2'd1;
				end
				ST_DIV_WAIT: begin
					if (div_done)
						job_q <= job_q + 2'd1;
				end
				ST_UV: step_q <= step_q + 3'd1;
				ST_EMIT: begin
					if (vtx_load)
						vidx_q <= vidx_q + 3'd1;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid)
					item_q <= req;
			end
			ST_PEN: begin
				// capture the quad corners and pass-through texture coordinates
				x0_q <= base_x;
				x1_q <= x1_new;
				y0_q <= base_y;
				y1_q <= y1_new;
				xl_q <= base_x;
				xh_q <= x1_new;
				yt_q <= base_y;
				yb_q <= y1_new;
				u_q[0] <= item_q.tl_u;
				v_q[0] <= item_q.tl_v;
				u_q[1] <= item_q.bl_u;
				v_q[1] <= item_q.bl_v;
				u_q[2] <= item_q.tr_u;
				v_q[2] <= item_q.tr_v;
				u_q[3] <= item_q.br_u;
				v_q[3] <= item_q.br_v;
			end
			ST_WIN: begin
				// negative origins shrink the window and move to zero
				win_l_q  <= cl_s[WIN_W-1] ? '0 : cl_s;
				win_t_q  <= ct_s[WIN_W-1] ? '0 : ct_s;
				win_r_q  <= cl_s + WIN_W'(clip_w_q);
				win_b_q  <= ct_s + WIN_W'(clip_h_q);
				du_neg_q <= item_q.br_u < item_q.tl_u;
				dv_neg_q <= item_q.br_v < item_q.tl_v;
				du_mag_q <= (item_q.br_u >= item_q.tl_u) ? item_q.br_u - item_q.tl_u :
					item_q.tl_u - item_q.br_u;
				dv_mag_q <= (item_q.br_v >= item_q.tl_v) ? item_q.br_v - item_q.tl_v :
					item_q.tl_v - item_q.br_v;
			end
			ST_CLIP: begin
				// clamp into the window; the far side cannot cross on a kept quad
				xl_q <= (x0_s < win_l_q) ? win_l_q[COORD_BITS-1:0] : x0_q;
				yt_q <= (y0_s < win_t_q) ? win_t_q[COORD_BITS-1:0] : y0_q;
				xh_q <= (x1_s > win_r_q) ? win_r_q[COORD_BITS-1:0] : x1_q;
				yb_q <= (y1_s > win_b_q) ? win_b_q[COORD_BITS-1:0] : y1_q;
			end
			ST_DELTA: begin
				d_q[0] <= xl_q - x0_q;
				d_q[1] <= x1_q - xh_q;
				d_q[2] <= yt_q - y0_q;
				d_q[3] <= y1_q - yb_q;
			end
			ST_MUL: begin
				// right and bottom offsets move inward, so their sign is negative
				prod_q <= PROD_W'(d_sel) * PROD_W'(mag_sel);
				pneg_q <= job_q[0] ^ (job_q[1] ? dv_neg_q : du_neg_q);
				skip_q <= (d_sel == '0) || (mag_sel == '0) || (size_sel == '0);
			end
			ST_DIV_GO: begin
				if (skip_q) begin
					qs_q[job_q]   <= '0;
					qneg_q[job_q] <= 1'b0;
				end
			end
			ST_DIV_WAIT: begin
				// any quotient past the texture range saturates either way
				if (div_done) begin
					qs_q[job_q]   <= (|div_quot[DIV_W-1:UV_W]) ? {1'b1, {UV_W{1'b0}}} :
						div_quot[QS_W-1:0];
					qneg_q[job_q] <= pneg_q;
				end
			end
			ST_UV: begin
				if (uv_isv)
					v_q[rd_k] <= uv_new;
				else
					u_q[rd_k] <= uv_new;
			end
			ST_EMIT: begin
				if (vtx_load) begin
					vtx_q.vert_x    <= rd_k[1] ? xh_q : xl_q;
					vtx_q.vert_y    <= rd_k[0] ? yb_q : yt_q;
					vtx_q.vert_u    <= u_q[rd_k];
					vtx_q.vert_v    <= v_q[rd_k];
					vtx_q.quad_done <= vidx_q == LAST_VERTEX;
				end
			end
			default: ;
		endcase
	end

	// Shared divider for the rounded texture shifts
	gqlc_div #(
		.DIVIDEND_W (DIV_W),
		.DIVISOR_W  (SIZE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DIV_W'(prod_q) + DIV_W'(size_sel >> 1)),
		.divisor  (size_sel),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign vtx_valid = vtx_valid_q;
	assign vtx       = vtx_q;

endmodule

@@ hdl/gqlc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the glyph quad layout clipper and its bind.
module gqlc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                vtx_valid,
	input logic                vtx_ready,
	input gqlc_pkg::gqlc_vtx_t vtx
);
	import gqlc_pkg::*;

	logic [2:0] cnt_q;

	// Count vertices taken within the current quad
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (vtx_valid && vtx_ready)
			cnt_q <= vtx.quad_done ? 3'd0 : cnt_q + 3'd1;
	end

	// Stalled vertex holds
	a_vtx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && !vtx_ready |=> vtx_valid && $stable(vtx))
		else $error("vertex changed while stalled");

	// An accepted request closes the input in the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("input still ready after a request");

	// Every quad is six vertices with the mark on the last
	a_quad_len: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid |-> (vtx.quad_done == (cnt_q == LAST_VERTEX)))
		else $error("quad_done out of place");

	// No new request while a quad is partly delivered
	a_no_req_mid_quad: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && !vtx.quad_done |-> !req_ready)
		else $error("input ready in the middle of a quad");

endmodule

bind glyph_quad_layout_clipper gqlc_checker u_gqlc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.vtx_valid (vtx_valid),
	.vtx_ready (vtx_ready),
	.vtx       (vtx)
);
